// File: design/dtps_pkg.sv
// Package for the depth-tested pixel store: field widths, command codes,
// configuration register indexes and the controller/datapath interface structs.
// Depends on nothing; used by every module of the block.
package dtps_pkg;

    // Fixed widths of the item fields and configuration registers.
    localparam int COORD_W      = 16;
    localparam int COLOR_W      = 32;
    localparam int DEPTH_PORT_W = 24;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int PROD_W       = 2 * CFG_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Reset value of both area registers.
    localparam logic [CFG_W-1:0] CFG_AREA_RESET = 9'd256;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int DEPTH_BITS_DEF = 24;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_CLR_DEPTH = 2'd1,
        CMD_CLR_ALL   = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // latch the accepted input item
        logic calc;        // register address, area test and clear count
        logic sweep_en;    // write one entry of a clearing sweep
        logic sweep_all;   // sweep covers the whole store (reset pass)
        logic sweep_color; // sweep clears the colours as well
        logic finish;      // load the result register, do the pixel write
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t command;
        logic sweep_done;
        logic out_free;
    } status_t;

endpackage

// File: design/dtps_ctrl.sv
// Controller of the depth-tested pixel store: one-hot state machine that
// sequences the reset clearing pass, clears, and pixel read-modify-writes.
// Depends on dtps_pkg.
module dtps_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtps_pkg::status_t  status,
    output dtps_pkg::ctrl_t    ctrl
);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CALC   = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        ctrl             = '0;
        ctrl.load        = in_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.sweep_en    = 1'b1;
                ctrl.sweep_all   = 1'b1;
                ctrl.sweep_color = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                ctrl.calc = 1'b1;
                if (status.command == dtps_pkg::CMD_CLR_DEPTH ||
                    status.command == dtps_pkg::CMD_CLR_ALL)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_SWEEP:
            begin
                ctrl.sweep_en    = 1'b1;
                ctrl.sweep_color = (status.command == dtps_pkg::CMD_CLR_ALL);
                if (status.sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/dtps_datapath.sv
// Datapath of the depth-tested pixel store: area registers, input latch,
// address generation, colour and depth memories, sweep counter and result register.
// Depends on dtps_pkg; driven by dtps_ctrl.
module dtps_datapath
#(
    parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtps_pkg::DEPTH_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dtps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dtps_pkg::CFG_W-1:0]             cfg_data,
    input  logic [1:0]                             command,
    input  logic signed [dtps_pkg::COORD_W-1:0]    pos_x,
    input  logic signed [dtps_pkg::COORD_W-1:0]    pos_y,
    input  logic [dtps_pkg::COLOR_W-1:0]           color_in,
    input  logic [dtps_pkg::DEPTH_PORT_W-1:0]      depth_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [dtps_pkg::COLOR_W-1:0]           color_out,
    output logic [dtps_pkg::DEPTH_PORT_W-1:0]      depth_out,
    output logic                                   in_range,
    output logic                                   written,
    input  dtps_pkg::ctrl_t                        ctrl,
    output dtps_pkg::status_t                      status
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CNT_W      = ADDR_W + 1;
    localparam logic [CNT_W-1:0] STORE_LIM = CNT_W'(STORE_SIZE);

    // Area registers.
    logic [dtps_pkg::CFG_W-1:0] active_width_reg;
    logic [dtps_pkg::CFG_W-1:0] active_height_reg;
    logic [dtps_pkg::CFG_W-1:0] eff_w;
    logic [dtps_pkg::CFG_W-1:0] eff_h;

    // Latched input item.
    dtps_pkg::cmd_t                       command_reg;
    logic signed [dtps_pkg::COORD_W-1:0]  pos_x_reg;
    logic signed [dtps_pkg::COORD_W-1:0]  pos_y_reg;
    logic [dtps_pkg::COLOR_W-1:0]         color_reg;
    logic [dtps_pkg::DEPTH_PORT_W-1:0]    depth_reg;

    // Address stage.
    logic                        in_area;
    logic                        in_area_reg;
    logic [dtps_pkg::PROD_W-1:0] row_base;
    logic [dtps_pkg::PROD_W-1:0] pix_index;
    logic [dtps_pkg::PROD_W-1:0] area;
    logic [ADDR_W-1:0]           addr_reg;
    logic [CNT_W-1:0]            count_reg;

    // Sweep.
    logic [CNT_W-1:0] sweep_cnt_reg;
    logic [CNT_W-1:0] sweep_lim;
    logic [CNT_W:0]   sweep_cnt_inc;
    logic             sweep_in_lim;

    // Memories.
    logic [dtps_pkg::COLOR_W-1:0] color_mem [STORE_SIZE];
    logic [DEPTH_BITS-1:0]        depth_mem [STORE_SIZE];
    logic [dtps_pkg::COLOR_W-1:0] rd_color_reg;
    logic [DEPTH_BITS-1:0]        rd_depth_reg;
    logic [ADDR_W-1:0]            wr_addr;
    logic                         color_we;
    logic                         depth_we;
    logic [dtps_pkg::COLOR_W-1:0] color_wdata;
    logic [DEPTH_BITS-1:0]        depth_wdata;
    logic [DEPTH_BITS-1:0]        frag_depth;
    logic                         is_write;
    logic                         is_read;
    logic                         depth_pass;
    logic                         pix_we;

    // Result register.
    logic                              out_valid_reg;
    logic [dtps_pkg::COLOR_W-1:0]      color_out_reg;
    logic [dtps_pkg::DEPTH_PORT_W-1:0] depth_out_reg;
    logic                              in_range_reg;
    logic                              written_reg;

    // An area larger than the store saturates to the store's size.
    assign eff_w = (32'(active_width_reg) > MAX_WIDTH) ?
                   dtps_pkg::CFG_W'(MAX_WIDTH) : active_width_reg;
    assign eff_h = (32'(active_height_reg) > MAX_HEIGHT) ?
                   dtps_pkg::CFG_W'(MAX_HEIGHT) : active_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= dtps_pkg::CFG_AREA_RESET;
            active_height_reg <= dtps_pkg::CFG_AREA_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dtps_pkg::CFG_IDX_WIDTH)
            begin
                active_width_reg <= cfg_data;
            end
            else
            begin
                active_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            command_reg <= dtps_pkg::cmd_t'(command);
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            color_reg   <= color_in;
            depth_reg   <= depth_in;
        end
    end

    // Inside the area both coordinates are below 512, so nine bits carry them.
    assign in_area = !pos_x_reg[dtps_pkg::COORD_W-1] && !pos_y_reg[dtps_pkg::COORD_W-1] &&
                     (pos_x_reg[dtps_pkg::COORD_W-2:0] < (dtps_pkg::COORD_W-1)'(eff_w)) &&
                     (pos_y_reg[dtps_pkg::COORD_W-2:0] < (dtps_pkg::COORD_W-1)'(eff_h));
    assign row_base  = dtps_pkg::PROD_W'(pos_y_reg[dtps_pkg::CFG_W-1:0]) *
                       dtps_pkg::PROD_W'(eff_w);
    assign pix_index = row_base + dtps_pkg::PROD_W'(pos_x_reg[dtps_pkg::CFG_W-1:0]);
    assign area      = dtps_pkg::PROD_W'(eff_w) * dtps_pkg::PROD_W'(eff_h);

    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            in_area_reg <= in_area;
            addr_reg    <= ADDR_W'(pix_index);
            count_reg   <= CNT_W'(area);
        end
    end

    // Sweep counter: cleared at the start of every item, stepped while sweeping.
    assign sweep_lim     = ctrl.sweep_all ? STORE_LIM : count_reg;
    assign sweep_cnt_inc = {1'b0, sweep_cnt_reg} + 1'b1;
    assign sweep_in_lim  = (sweep_cnt_reg < sweep_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (ctrl.calc)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (ctrl.sweep_en && sweep_in_lim)
        begin
            sweep_cnt_reg <= sweep_cnt_inc[CNT_W-1:0];
        end
    end

    // Depth test and memory write port.
    assign frag_depth = DEPTH_BITS'(depth_reg);
    assign is_write   = (command_reg == dtps_pkg::CMD_WRITE);
    assign is_read    = (command_reg == dtps_pkg::CMD_READ);
    assign depth_pass = (frag_depth <= rd_depth_reg);
    assign pix_we     = ctrl.finish && is_write && in_area_reg && depth_pass;

    assign wr_addr     = ctrl.sweep_en ? sweep_cnt_reg[ADDR_W-1:0] : addr_reg;
    assign color_we    = (ctrl.sweep_en && ctrl.sweep_color && sweep_in_lim) || pix_we;
    assign depth_we    = (ctrl.sweep_en && sweep_in_lim) || pix_we;
    assign color_wdata = ctrl.sweep_en ? '0 : color_reg;
    assign depth_wdata = ctrl.sweep_en ? '1 : frag_depth;

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[wr_addr] <= color_wdata;
        end
        rd_color_reg <= color_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[wr_addr] <= depth_wdata;
        end
        rd_depth_reg <= depth_mem[addr_reg];
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            color_out_reg <= (is_read && in_area_reg) ? rd_color_reg : '0;
            depth_out_reg <= (is_read && in_area_reg) ?
                             dtps_pkg::DEPTH_PORT_W'(rd_depth_reg) : '0;
            in_range_reg  <= (is_read || is_write) && in_area_reg;
            written_reg   <= pix_we;
        end
    end

    assign out_valid = out_valid_reg;
    assign color_out = color_out_reg;
    assign depth_out = depth_out_reg;
    assign in_range  = in_range_reg;
    assign written   = written_reg;

    assign status.command    = command_reg;
    assign status.sweep_done = (sweep_cnt_inc >= {1'b0, sweep_lim});
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

// File: design/depth_tested_pixel_store_unit.sv
// Top level of the depth-tested pixel store (z-buffer with colour store).
// Depends on dtps_pkg, dtps_ctrl and dtps_datapath.
//
// Usage. Items enter on the in_valid/in_ready channel: a command, a signed
// position, a colour and a depth. Every item gives exactly one result on the
// out_valid/out_ready channel. A depth-tested write replaces colour and depth
// when the position is inside the active area and its depth is less than or
// equal to the stored one; a read inside the area returns the stored pair; the two clear
// commands sweep the first width*height entries to the far depth (and colour
// zero for the full clear). The user writes the area registers through cfg_we,
// cfg_index and cfg_data while the block is idle; the block does not enforce it.
// Timing. A write or read passes through the latch, address, memory read and
// update steps of the read-modify-write before the next item is accepted; its
// result becomes valid when the update step loads the result register. A clear
// writes one memory entry per cycle while it sweeps, then takes the update step.
// Reset. After reset the block runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// entries (65536 by default), with in_ready low, which sets every colour to zero
// and every depth to the far value. Configuration writes are taken meanwhile.
// Stalls. The result waits in an output register; the block still accepts and
// works on the next item, holding it in its last step until the register frees.
module depth_tested_pixel_store_unit
#(
    parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dtps_pkg::DEPTH_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dtps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dtps_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             command,
    input  logic signed [dtps_pkg::COORD_W-1:0]    pos_x,
    input  logic signed [dtps_pkg::COORD_W-1:0]    pos_y,
    input  logic [dtps_pkg::COLOR_W-1:0]           color_in,
    input  logic [dtps_pkg::DEPTH_PORT_W-1:0]      depth_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [dtps_pkg::COLOR_W-1:0]           color_out,
    output logic [dtps_pkg::DEPTH_PORT_W-1:0]      depth_out,
    output logic                                   in_range,
    output logic                                   written
);

    // The controller sequences each item; the datapath holds the stores.
    dtps_pkg::ctrl_t   ctrl;
    dtps_pkg::status_t status;

    dtps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    dtps_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .color_in  (color_in),
        .depth_in  (depth_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .color_out (color_out),
        .depth_out (depth_out),
        .in_range  (in_range),
        .written   (written),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule
